// ----- src/pes_pkg.sv -----
// Shared package of the pursue/evade steering unit: widths, transaction types,
// mode codes and request/response structs of the iterative arithmetic units.
// No dependencies.
package pes_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int MS_W   = 24;
    localparam int DT_W   = 17;
    localparam int W      = 32;
    localparam logic [MS_W-1:0] MS_RESET = 24'd196608;

    // sqrt of a sum of three squares of 33-bit magnitudes
    localparam int RAD_W  = 66;
    localparam int ROOT_W = 33;
    // shared divider
    localparam int DVD_W  = 60;
    localparam int DVS_W  = 33;
    // shared multiplier operand width (unsigned magnitudes)
    localparam int MUL_W  = 33;

    typedef enum logic [1:0] {
        FUNC_PURSUE = 2'd0,
        FUNC_EVADE  = 2'd1,
        FUNC_LOAD   = 2'd2,
        FUNC_HOLD   = 2'd3
    } t_func;

    typedef struct packed {
        t_func                 func;
        logic signed [W-1:0]   self_pos_x;
        logic signed [W-1:0]   self_pos_y;
        logic signed [W-1:0]   self_pos_z;
        logic signed [W-1:0]   other_pos_x;
        logic signed [W-1:0]   other_pos_y;
        logic signed [W-1:0]   other_pos_z;
        logic signed [W-1:0]   other_vel_x;
        logic signed [W-1:0]   other_vel_y;
        logic signed [W-1:0]   other_vel_z;
        logic [DT_W-1:0]       dt;
    } t_in_item;

    typedef struct packed {
        logic signed [W-1:0] new_vel_x;
        logic signed [W-1:0] new_vel_y;
        logic signed [W-1:0] new_vel_z;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] rad;
    } t_sqrt_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_rsp;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
    } t_div_rsp;

endpackage

// ----- src/pes_in_if.sv -----
// Input channel of the steering unit: valid/ready plus one input transaction.
// Depends on pes_pkg.
interface pes_in_if import pes_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- src/pes_out_if.sv -----
// Output channel of the steering unit: valid/ready plus one result transaction.
// Depends on pes_pkg.
interface pes_out_if import pes_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- src/pes_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pes_pkg.
module pes_div
    import pes_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_q;

    logic [DVS_W:0]   trial;
    logic             take;

    assign trial = {r_rem, r_q[DVD_W-1]};
    assign take  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
                r_dvs  <= i_req.divisor;
                r_q    <= i_req.dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= take ? DVS_W'(trial - {1'b0, r_dvs}) : trial[DVS_W-1:0];
                r_q   <= {r_q[DVD_W-2:0], take};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
endmodule

// ----- src/pes_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on pes_pkg.
module pes_sqrt
    import pes_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sqrt_req i_req,
    output t_sqrt_rsp o_rsp
);
    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 2;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [REM_W+1:0]  rem2;
    logic [REM_W+1:0]  trial;
    logic              take;

    assign rem2  = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign trial = (REM_W + 2)'({r_root, 2'b01});
    assign take  = rem2 >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W);
                r_rad  <= i_req.rad;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rem  <= take ? REM_W'(rem2 - trial) : REM_W'(rem2);
                r_root <= {r_root[ROOT_W-2:0], take};
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;
endmodule

// ----- src/pursue_evade_steering_unit.sv -----
// Pursue/evade steering unit, top level. A steering transaction takes longer when
// the speed clamp fires; load/hold transactions skip the arithmetic.
// Throughput: one transaction at a time, set by the 60-step shared divider (used
// up to seven times) and the 33-step square root unit (three times).
// Reset (synchronous, active low): velocity zero, max_speed 3.0, channels idle.
// Depends on pes_pkg, pes_in_if, pes_out_if, pes_div, pes_sqrt.
module pursue_evade_steering_unit
    import pes_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [MS_W-1:0] i_cfg_wdata,
    pes_in_if.sink          i_in,
    pes_out_if.source       o_out
);
    localparam int SW = 2 * MUL_W + 1;   // signed product width
    localparam logic signed [SW-1:0] S32_MAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] S32_MIN = SW'(-64'sd2147483648);

    // Sequencer: each vector goes through SQ_MUL/SQ_ACC three times and then
    // the square root; the phase says which vector's length that was.
    typedef enum logic [3:0] {
        S_IDLE, S_SQ_MUL, S_SQ_ACC, S_SQRT_WAIT, S_LOOK_WAIT,
        S_PRED_MUL, S_PRED_ADD, S_WANT_MUL, S_WANT_DIV, S_WANT_WAIT,
        S_STEER_MUL, S_STEER_ADD, S_CLAMP_MUL, S_CLAMP_DIV, S_CLAMP_WAIT,
        S_COMMIT_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_DIST,   // other_pos - self_pos, for the look-ahead
        PH_AIM,    // predicted point - self_pos, for the desired velocity
        PH_VEL     // updated velocity, for the speed clamp
    } t_phase;

    function automatic logic signed [W-1:0] sat32(input logic signed [SW-1:0] x);
        if (x > S32_MAX) begin
            return S32_MAX[W-1:0];
        end else if (x < S32_MIN) begin
            return S32_MIN[W-1:0];
        end
        return x[W-1:0];
    endfunction

    t_state r_state;
    t_phase r_phase;
    logic   r_out;              // result waiting on the output
    logic [1:0] r_k;            // component index
    logic [MS_W-1:0] r_ms;
    logic signed [W-1:0] r_vel  [3];
    logic signed [W-1:0] r_self [3];
    logic signed [W-1:0] r_opos [3];
    logic signed [W-1:0] r_ovel [3];
    logic [DT_W-1:0]     r_dt;
    logic                r_evade;
    logic signed [W:0]   r_vec  [3];   // working vector, 33-bit signed
    logic [RAD_W-1:0]    r_acc;
    logic [2*MUL_W-1:0]  r_prod;
    logic [ROOT_W-1:0]   r_look;
    logic [ROOT_W-1:0]   r_len;
    logic signed [26:0]  r_want;
    logic                r_st_neg;

    t_sqrt_req sq_req;
    t_sqrt_rsp sq_rsp;
    t_div_req  dv_req;
    t_div_rsp  dv_rsp;

    // shared multiplier
    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [2*MUL_W-1:0]  mul_p;

    logic signed [W:0]   vk;
    logic [W:0]          vk_mag;
    logic signed [W-1:0] ovk;
    logic [W-1:0]        ovk_mag;
    logic signed [33:0]  st_raw;
    logic signed [33:0]  st;
    logic [W:0]          st_mag;
    logic [25:0]         speed;
    logic [MS_W-1:0]     ipart;
    logic [25:0]         look_div;
    logic signed [SW-1:0] prod_pos;
    logic signed [SW-1:0] prod_neg;
    logic signed [SW-1:0] pred_sum;
    logic signed [W:0]    aim;
    logic signed [SW-1:0] step_sh;
    logic signed [W-1:0]  new_v;
    logic signed [26:0]   want;
    logic signed [W:0]    clamped;

    assign vk       = r_vec[r_k];
    assign vk_mag   = vk[W] ? (W+1)'(-vk) : (W+1)'(vk);
    assign ovk      = r_ovel[r_k];
    assign ovk_mag  = ovk[W-1] ? W'(-ovk) : W'(ovk);
    assign st_raw   = 34'(r_want) - 34'(r_vel[r_k]);
    assign st       = r_evade ? -st_raw : st_raw;
    assign st_mag   = st[33] ? (W+1)'(-st) : (W+1)'(st);
    assign speed    = r_evade ? 26'({r_ms, 1'b0}) + 26'(r_ms) : 26'(r_ms);
    assign ipart    = (r_ms >> FRAC_BITS) == '0 ? MS_W'(1) : (r_ms >> FRAC_BITS);
    assign look_div = r_evade ? 26'({ipart, 1'b0}) + 26'(ipart) : 26'(ipart);

    assign prod_pos = $signed({1'b0, r_prod});
    assign prod_neg = -prod_pos;

    // predicted point, saturated, minus own position
    assign pred_sum = SW'(r_opos[r_k]) + (ovk[W-1] ? prod_neg : prod_pos);
    assign aim      = (W+1)'(sat32(pred_sum)) - (W+1)'(r_self[r_k]);

    // floor(steer * dt / 2^FRAC_BITS) added to the old velocity
    assign step_sh  = (r_st_neg ? prod_neg : prod_pos) >>> FRAC_BITS;
    assign new_v    = sat32(SW'(r_vel[r_k]) + step_sh);

    // quotients carry the sign of the numerator, truncating toward zero
    assign want     = vk[W] ? -$signed({1'b0, dv_rsp.quot[25:0]})
                            :  $signed({1'b0, dv_rsp.quot[25:0]});
    assign clamped  = vk[W] ? -$signed({1'b0, dv_rsp.quot[W-1:0]})
                            :  $signed({1'b0, dv_rsp.quot[W-1:0]});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ_MUL: begin
                mul_a = vk_mag;
                mul_b = vk_mag;
            end
            S_PRED_MUL: begin
                mul_a = MUL_W'(ovk_mag);
                mul_b = MUL_W'(r_look);
            end
            S_WANT_MUL: begin
                mul_a = vk_mag;
                mul_b = MUL_W'(speed);
            end
            S_STEER_MUL: begin
                mul_a = st_mag;
                mul_b = MUL_W'(r_dt);
            end
            S_CLAMP_MUL: begin
                mul_a = vk_mag;
                mul_b = MUL_W'(r_ms);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // square root request: the final square is added on the way in
    assign sq_req.start = (r_state == S_SQ_ACC) && (r_k == 2'd2);
    assign sq_req.rad   = r_acc + r_prod;

    // divider: look-ahead, desired velocity and clamp share one unit
    always_comb begin
        dv_req.start    = 1'b0;
        dv_req.dividend = r_prod[DVD_W-1:0];
        dv_req.divisor  = r_len;
        case (r_state)
            S_SQRT_WAIT: begin
                dv_req.start    = sq_rsp.done && (r_phase == PH_DIST);
                dv_req.dividend = DVD_W'(sq_rsp.root >> FRAC_BITS);
                dv_req.divisor  = DVS_W'(look_div);
            end
            S_WANT_DIV, S_CLAMP_DIV: begin
                dv_req.start = 1'b1;
            end
            default: begin
                dv_req.start = 1'b0;
            end
        endcase
    end

    pes_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_rsp   (sq_rsp)
    );

    pes_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dv_req),
        .o_rsp   (dv_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_DIST;
            r_out   <= 1'b0;
            r_k     <= '0;
            r_ms    <= MS_RESET;
            for (int i = 0; i < 3; i++) begin
                r_vel[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_ms <= i_cfg_wdata;
            end
            r_prod <= mul_p;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_self[0] <= i_in.payload.self_pos_x;
                        r_self[1] <= i_in.payload.self_pos_y;
                        r_self[2] <= i_in.payload.self_pos_z;
                        r_opos[0] <= i_in.payload.other_pos_x;
                        r_opos[1] <= i_in.payload.other_pos_y;
                        r_opos[2] <= i_in.payload.other_pos_z;
                        r_ovel[0] <= i_in.payload.other_vel_x;
                        r_ovel[1] <= i_in.payload.other_vel_y;
                        r_ovel[2] <= i_in.payload.other_vel_z;
                        r_dt      <= i_in.payload.dt;
                        r_evade   <= i_in.payload.func == FUNC_EVADE;
                        r_vec[0]  <= (W+1)'(i_in.payload.other_pos_x)
                                   - (W+1)'(i_in.payload.self_pos_x);
                        r_vec[1]  <= (W+1)'(i_in.payload.other_pos_y)
                                   - (W+1)'(i_in.payload.self_pos_y);
                        r_vec[2]  <= (W+1)'(i_in.payload.other_pos_z)
                                   - (W+1)'(i_in.payload.self_pos_z);
                        r_k       <= '0;
                        r_acc     <= '0;
                        r_phase   <= PH_DIST;
                        unique case (i_in.payload.func)
                            FUNC_PURSUE, FUNC_EVADE: begin
                                r_state <= S_SQ_MUL;
                            end
                            FUNC_LOAD: begin
                                r_vel[0] <= i_in.payload.other_vel_x;
                                r_vel[1] <= i_in.payload.other_vel_y;
                                r_vel[2] <= i_in.payload.other_vel_z;
                                r_out    <= 1'b1;
                                r_state  <= S_COMMIT_OUT;
                            end
                            FUNC_HOLD: begin
                                r_out   <= 1'b1;
                                r_state <= S_COMMIT_OUT;
                            end
                        endcase
                    end
                end
                S_SQ_MUL: begin
                    r_state <= S_SQ_ACC;
                end
                S_SQ_ACC: begin
                    r_acc <= r_acc + r_prod;
                    if (r_k == 2'd2) begin
                        r_k     <= '0;
                        r_state <= S_SQRT_WAIT;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_SQ_MUL;
                    end
                end
                S_SQRT_WAIT: begin
                    if (sq_rsp.done) begin
                        r_len <= sq_rsp.root;
                        unique case (r_phase)
                            PH_DIST: begin
                                r_state <= S_LOOK_WAIT;
                            end
                            PH_AIM: begin
                                if (sq_rsp.root == '0) begin
                                    r_want  <= '0;
                                    r_state <= S_STEER_MUL;
                                end else begin
                                    r_state <= S_WANT_MUL;
                                end
                            end
                            default: begin
                                if (sq_rsp.root > ROOT_W'(r_ms)) begin
                                    r_state <= S_CLAMP_MUL;
                                end else begin
                                    r_state <= S_COMMIT_OUT;
                                end
                            end
                        endcase
                    end
                end
                S_LOOK_WAIT: begin
                    if (dv_rsp.done) begin
                        r_look  <= dv_rsp.quot[ROOT_W-1:0];
                        r_state <= S_PRED_MUL;
                    end
                end
                S_PRED_MUL: begin
                    r_state <= S_PRED_ADD;
                end
                S_PRED_ADD: begin
                    r_vec[r_k] <= aim;
                    if (r_k == 2'd2) begin
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_phase <= PH_AIM;
                        r_state <= S_SQ_MUL;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_PRED_MUL;
                    end
                end
                S_WANT_MUL: begin
                    r_state <= S_WANT_DIV;
                end
                S_WANT_DIV: begin
                    r_state <= S_WANT_WAIT;
                end
                S_WANT_WAIT: begin
                    if (dv_rsp.done) begin
                        r_want  <= want;
                        r_state <= S_STEER_MUL;
                    end
                end
                S_STEER_MUL: begin
                    r_st_neg <= st[33];
                    r_state  <= S_STEER_ADD;
                end
                S_STEER_ADD: begin
                    r_vec[r_k] <= (W+1)'(new_v);
                    if (r_k == 2'd2) begin
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_phase <= PH_VEL;
                        r_state <= S_SQ_MUL;
                    end else begin
                        r_k <= r_k + 2'd1;
                        if (r_len == '0) begin
                            r_want  <= '0;
                            r_state <= S_STEER_MUL;
                        end else begin
                            r_state <= S_WANT_MUL;
                        end
                    end
                end
                S_CLAMP_MUL: begin
                    r_state <= S_CLAMP_DIV;
                end
                S_CLAMP_DIV: begin
                    r_state <= S_CLAMP_WAIT;
                end
                S_CLAMP_WAIT: begin
                    if (dv_rsp.done) begin
                        r_vec[r_k] <= clamped;
                        if (r_k == 2'd2) begin
                            r_k     <= '0;
                            r_state <= S_COMMIT_OUT;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_CLAMP_MUL;
                        end
                    end
                end
                S_COMMIT_OUT: begin
                    // first cycle: steering result lands in the velocity state
                    if (!r_out) begin
                        for (int i = 0; i < 3; i++) begin
                            r_vel[i] <= r_vec[i][W-1:0];
                        end
                        r_out <= 1'b1;
                    end else if (o_out.ready) begin
                        r_out   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign i_in.ready              = r_state == S_IDLE;
    assign o_out.valid             = (r_state == S_COMMIT_OUT) && r_out;
    assign o_out.payload.new_vel_x = r_vel[0];
    assign o_out.payload.new_vel_y = r_vel[1];
    assign o_out.payload.new_vel_z = r_vel[2];

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input taken while a result is pending");

    a_units_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sq_req.start && dv_req.start))
        else $error("square root and divider started together");

    a_load_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.payload.func == FUNC_LOAD)
        |=> (o_out.valid && o_out.payload.new_vel_x == $past(i_in.payload.other_vel_x)))
        else $error("load transaction did not return the loaded velocity");

    a_div_no_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_req.start |-> (dv_req.divisor != '0))
        else $error("divider started with a zero divisor");
`endif
endmodule
